// ===== rtl/tlps_pkg.sv =====
package tlps_pkg;

    localparam int MAX_WAYS  = 4;
    localparam int TIME_BITS = 8;

    localparam int WAY_SLOTS    = 4;
    localparam int WAY_BITS     = 2;
    localparam int COUNT_BITS   = 3;
    localparam int CFG_BITS     = 8;
    localparam int REG_IDX_BITS = 3;
    localparam int IN_BITS      = 8;
    localparam int OUT_BITS     = 16;
    localparam int WAY_LIM      = (MAX_WAYS < WAY_SLOTS) ? MAX_WAYS : WAY_SLOTS;
    localparam int unsigned TIME_MAX = (1 << TIME_BITS) - 1;

    localparam logic [COUNT_BITS-1:0] WAY_COUNT_RST   = 3'd2;
    localparam logic [CFG_BITS-1:0]   GREEN_TIME_RST  = 8'd60;
    localparam logic [CFG_BITS-1:0]   YELLOW_TIME_RST = 8'd10;

    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_RED    = 2'd1,
        COLOR_YELLOW = 2'd2
    } color_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_WAY_COUNT = 3'd0,
        REG_GREEN_0   = 3'd1,
        REG_GREEN_1   = 3'd2,
        REG_GREEN_2   = 3'd3,
        REG_GREEN_3   = 3'd4,
        REG_YELLOW    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]               way_count;
        logic [WAY_SLOTS-1:0][CFG_BITS-1:0]  green_time;
        logic [CFG_BITS-1:0]                 yellow_time;
    } cfg_t;

    typedef struct packed {
        color_t [WAY_SLOTS-1:0]  colors;
        logic [WAY_BITS-1:0]     way;
        logic [TIME_BITS-1:0]    ticks;
    } phase_state_t;

    // packed so that it matches the output word layout, way 0 lowest
    typedef struct packed {
        logic [4:0]          pad;
        logic                phase_changed;
        logic [WAY_BITS-1:0] serving_way;
        color_t              light_way_3;
        color_t              light_way_2;
        color_t              light_way_1;
        color_t              light_way_0;
    } result_t;

    function automatic color_t next_color(input color_t c);
        color_t r;
        case (c)
            COLOR_GREEN:  r = COLOR_YELLOW;
            COLOR_YELLOW: r = COLOR_RED;
            default:      r = COLOR_GREEN;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] ways_in_use(input logic [COUNT_BITS-1:0] wc);
        logic [COUNT_BITS-1:0] n;
        n = wc;
        if (wc < 3'd2) begin
            n = 3'd2;
        end else if (32'(wc) > WAY_LIM) begin
            n = COUNT_BITS'(WAY_LIM);
        end
        return n;
    endfunction

    function automatic logic [TIME_BITS-1:0] fit_duration(input logic [CFG_BITS-1:0] d);
        logic [31:0] w;
        w = 32'(d);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > TIME_MAX) begin
            w = TIME_MAX;
        end
        return w[TIME_BITS-1:0];
    endfunction

endpackage

// ===== rtl/tlps_step.sv =====
module tlps_step (
    input  logic                   advance,
    input  tlps_pkg::cfg_t         cfg,
    input  tlps_pkg::phase_state_t cur,
    output tlps_pkg::phase_state_t nxt,
    output tlps_pkg::result_t      res
);
    import tlps_pkg::*;

    logic [COUNT_BITS-1:0] n;
    logic [COUNT_BITS-1:0] way_inc;
    logic [WAY_BITS-1:0]   w0;
    logic [WAY_BITS-1:0]   w1;
    color_t                c0;
    logic [CFG_BITS-1:0]   dur;
    logic                  changed;
    color_t [WAY_SLOTS-1:0] lights;

    always_comb begin
        n       = ways_in_use(cfg.way_count);
        nxt     = cur;
        changed = 1'b0;
        w0      = cur.way;
        w1      = cur.way;
        c0      = next_color(cur.colors[w0]);
        way_inc = {1'b0, w0} + 3'd1;
        dur     = cfg.green_time[w0];
        if (advance) begin
            if (cur.ticks == '0) begin
                changed       = 1'b1;
                nxt.colors[w0] = c0;
                if (c0 == COLOR_YELLOW) begin
                    dur = cfg.yellow_time;
                end else begin
                    if (c0 == COLOR_RED) begin
                        w1 = (way_inc >= n) ? '0 : way_inc[WAY_BITS-1:0];
                        nxt.colors[w1] = next_color(nxt.colors[w1]);
                    end
                    dur = cfg.green_time[w1];
                end
                nxt.way   = w1;
                nxt.ticks = fit_duration(dur) - TIME_BITS'(1);
            end else begin
                nxt.ticks = cur.ticks - TIME_BITS'(1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WAY_SLOTS; i++) begin
            lights[i] = (32'(i) < 32'(n)) ? nxt.colors[i] : COLOR_RED;
        end
        res.pad           = '0;
        res.phase_changed = changed;
        res.serving_way   = nxt.way;
        res.light_way_3   = lights[3];
        res.light_way_2   = lights[2];
        res.light_way_1   = lights[1];
        res.light_way_0   = lights[0];
    end

endmodule

// ===== rtl/traffic_light_phase_sequencer.sv =====
// An accepted tick word's result is registered in out_reg, or in skid_reg while m_ is stalled.
// Throughput: one tick word per cycle unless skid_reg is full; the phase update is combinational
// countdown compare and color step, and a skid register keeps s_tready up while one result waits.
// Reset (aresetn low, synchronous): all lights red, way 0 serving, event due at once,
// registers back to way_count 2, green 60, yellow 10, both channels empty.
module traffic_light_phase_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlps_pkg::IN_BITS-1:0]        s_tdata,   // [0] advance, [7:1] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlps_pkg::OUT_BITS-1:0]       m_tdata,   // [1:0] light_way_0, [3:2] light_way_1,
                                                           // [5:4] light_way_2, [7:6] light_way_3,
                                                           // [9:8] serving_way, [10] phase_changed
    input  logic                                cfg_we,
    input  logic [tlps_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [tlps_pkg::CFG_BITS-1:0]       cfg_wdata
);
    import tlps_pkg::*;

    cfg_t         cfg_reg;
    phase_state_t state_reg;
    phase_state_t state_next;
    result_t      res_next;
    result_t      out_reg;
    result_t      skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         s_accept;
    logic         out_free;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    tlps_step u_step (
        .advance (s_tdata[0]),
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.way_count   <= WAY_COUNT_RST;
            cfg_reg.green_time  <= {WAY_SLOTS{GREEN_TIME_RST}};
            cfg_reg.yellow_time <= YELLOW_TIME_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WAY_COUNT: cfg_reg.way_count     <= cfg_wdata[COUNT_BITS-1:0];
                REG_GREEN_0:   cfg_reg.green_time[0] <= cfg_wdata;
                REG_GREEN_1:   cfg_reg.green_time[1] <= cfg_wdata;
                REG_GREEN_2:   cfg_reg.green_time[2] <= cfg_wdata;
                REG_GREEN_3:   cfg_reg.green_time[3] <= cfg_wdata;
                REG_YELLOW:    cfg_reg.yellow_time   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.colors <= {WAY_SLOTS{COLOR_RED}};
            state_reg.way    <= '0;
            state_reg.ticks  <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // hold a result in the skid stage while the output word is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_free) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (out_free) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end else if (out_free && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

endmodule

// ===== sim/tb_traffic_light_phase_sequencer.sv =====
`timescale 1ns / 100ps

module tb_traffic_light_phase_sequencer;
    import tlps_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int ITEM_TARGET  = 1350;
    localparam int CALM_ITEMS   = 150;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_BITS-1:0]      s_tdata   = '0;   // [0] advance, [7:1] zero
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_BITS-1:0]     m_tdata;          // light_way_0..3, serving_way, phase_changed
    logic                    cfg_we    = 1'b0;
    logic [REG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;

    logic [IN_BITS-1:0] tick_words[$];
    result_t            lights_due[$];

    color_t                lamp[WAY_SLOTS];
    logic [WAY_BITS-1:0]   served;
    logic [TIME_BITS-1:0]  countdown;
    logic [COUNT_BITS-1:0] ways_cfg;
    logic [CFG_BITS-1:0]   green_cfg[WAY_SLOTS];
    logic [CFG_BITS-1:0]   yellow_cfg;

    int errors       = 0;
    int cycles       = 0;
    int words_queued = 0;
    int hold_asked   = 0;
    int hold_done    = 0;
    int hold_left    = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    bit calm         = 1'b0;

    traffic_light_phase_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_traffic_light_phase_sequencer NOT OK");
            $finish;
        end
    end

    task automatic report(input string what, input int unsigned got_v, input int unsigned want_v);
        $display("MISMATCH %s: got %0d, expected %0d", what, got_v, want_v);
        errors++;
    endtask

    function automatic color_t cycle_color(input color_t c);
        return (c == COLOR_GREEN) ? COLOR_YELLOW : ((c == COLOR_YELLOW) ? COLOR_RED : COLOR_GREEN);
    endfunction

    function automatic result_t predict_tick(input logic adv);
        result_t r;
        int      n;
        int      w;
        int      span;
        n = (ways_cfg < 2) ? 2 : ((int'(ways_cfg) > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg));
        r = '0;
        if (adv) begin
            if (countdown == 0) begin
                r.phase_changed = 1'b1;
                w = int'(served);
                lamp[w] = cycle_color(lamp[w]);
                if (lamp[w] == COLOR_YELLOW) begin
                    span = int'(yellow_cfg);
                end else begin
                    if (lamp[w] == COLOR_RED) begin
                        w = (w + 1 >= n) ? 0 : w + 1;
                        lamp[w] = cycle_color(lamp[w]);
                    end
                    span = int'(green_cfg[w]);
                end
                served = WAY_BITS'(w);
                if (span == 0) begin
                    span = 1;
                end
                if (span > int'(TIME_MAX)) begin
                    span = int'(TIME_MAX);
                end
                countdown = TIME_BITS'(span);
            end
            countdown = countdown - 1'b1;
        end
        r.light_way_0 = lamp[0];
        r.light_way_1 = lamp[1];
        r.light_way_2 = (n > 2) ? lamp[2] : COLOR_RED;
        r.light_way_3 = (n > 3) ? lamp[3] : COLOR_RED;
        r.serving_way = served;
        return r;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_span(input bit allow_long);
        logic [CFG_BITS-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = 8'd0;
            1:       v = allow_long ? 8'd255 : 8'd1;
            default: v = 8'($urandom_range(1, 6));
        endcase
        return v;
    endfunction

    // driver: offer queued tick words, hold each until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(tick_words.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 6);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_words.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tick_words[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (recv_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 6);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted ticks, check each result word
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                lights_due = {lights_due, predict_tick(s_tdata[0])};
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (lights_due.size() == 0) begin
                    report("result word with nothing expected", m_tdata, 0);
                end else begin
                    want = lights_due.pop_front();
                    if (got.light_way_0 !== want.light_way_0) begin
                        report("light_way_0", got.light_way_0, want.light_way_0);
                    end
                    if (got.light_way_1 !== want.light_way_1) begin
                        report("light_way_1", got.light_way_1, want.light_way_1);
                    end
                    if (got.light_way_2 !== want.light_way_2) begin
                        report("light_way_2", got.light_way_2, want.light_way_2);
                    end
                    if (got.light_way_3 !== want.light_way_3) begin
                        report("light_way_3", got.light_way_3, want.light_way_3);
                    end
                    if (got.serving_way !== want.serving_way) begin
                        report("serving_way", got.serving_way, want.serving_way);
                    end
                    if (got.phase_changed !== want.phase_changed) begin
                        report("phase_changed", got.phase_changed, want.phase_changed);
                    end
                end
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_WAY_COUNT: ways_cfg = v[COUNT_BITS-1:0];
            REG_GREEN_0:   green_cfg[0] = v;
            REG_GREEN_1:   green_cfg[1] = v;
            REG_GREEN_2:   green_cfg[2] = v;
            REG_GREEN_3:   green_cfg[3] = v;
            REG_YELLOW:    yellow_cfg = v;
            default:       ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_ticks(input int count, input int zero_share);
        @(negedge aclk);
        repeat (count) begin
            tick_words = {tick_words, IN_BITS'($urandom_range(0, 99) >= zero_share)};
        end
        words_queued += count;
    endtask

    task automatic settle();
        do begin
            @(negedge aclk);
        end while (tick_words.size() != 0 || s_tvalid || lights_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int phase;
        int len;
        foreach (lamp[i]) begin
            lamp[i]      = COLOR_RED;
            green_cfg[i] = GREEN_TIME_RST;
        end
        served     = '0;
        countdown  = '0;
        ways_cfg   = WAY_COUNT_RST;
        yellow_cfg = YELLOW_TIME_RST;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // report-only word straight out of reset
        add_ticks(1, 100);
        settle();

        // fast cycle through four ways, zero durations included
        write_reg(REG_WAY_COUNT, 8'd4);
        write_reg(REG_GREEN_0, 8'd1);
        write_reg(REG_GREEN_1, 8'd2);
        write_reg(REG_GREEN_2, 8'd0);
        write_reg(REG_GREEN_3, 8'd1);
        write_reg(REG_YELLOW, 8'd0);
        add_ticks(24, 0);

        phase = 0;
        while (words_queued < ITEM_TARGET) begin
            settle();
            if (phase == 3) begin
                // longest durations: let a full countdown expire
                write_reg(REG_WAY_COUNT, 8'd2);
                write_reg(REG_GREEN_0, 8'd255);
                write_reg(REG_GREEN_1, 8'd255);
                write_reg(REG_GREEN_2, 8'd255);
                write_reg(REG_GREEN_3, 8'd255);
                write_reg(REG_YELLOW, 8'd255);
                len = 300;
            end else begin
                if (phase == 4) begin
                    write_reg(REG_GREEN_0, 8'd1);
                    write_reg(REG_GREEN_1, 8'd1);
                    write_reg(REG_GREEN_2, 8'd1);
                    write_reg(REG_GREEN_3, 8'd1);
                    write_reg(REG_YELLOW, 8'd1);
                end
                if ($urandom_range(0, 2) != 0) begin
                    write_reg(REG_WAY_COUNT, ($urandom_range(0, 3) == 0) ?
                              8'($urandom_range(0, 255)) : 8'($urandom_range(2, 4)));
                end
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(REG_GREEN_0, pick_span(phase > 3));
                end
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(REG_GREEN_1, pick_span(phase > 3));
                end
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(REG_GREEN_2, pick_span(phase > 3));
                end
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(REG_GREEN_3, pick_span(phase > 3));
                end
                if ($urandom_range(0, 1) != 0) begin
                    write_reg(REG_YELLOW, pick_span(phase > 3));
                end
                len = $urandom_range(30, 100);
            end
            if (words_queued + len >= ITEM_TARGET - CALM_ITEMS) begin
                calm = 1'b1;
            end
            add_ticks(len, (phase == 3) ? 0 : $urandom_range(0, 30));
            if (phase == 2) begin
                hold_asked++;
            end
            phase++;
        end
        settle();

        if (errors == 0) begin
            $display("tb_traffic_light_phase_sequencer OK");
        end else begin
            $display("tb_traffic_light_phase_sequencer NOT OK");
        end
        $finish;
    end

endmodule
